[rtl/ttybm_pkg.sv]
// Shared types and constants of the terminal line-discipline byte mapper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ttybm_pkg;

  // Character codes used by the mapping rules.
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] MASK_7BIT  = 8'h7F;

  // Destination codes of a result.
  localparam logic DEST_INPUT  = 1'b0;
  localparam logic DEST_OUTPUT = 1'b1;

  // Action codes of an input item.
  localparam logic ACT_RX = 1'b0;
  localparam logic ACT_TX = 1'b1;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INPUT_MODE  = 2'd0,
    REG_OUTPUT_MODE = 2'd1,
    REG_ECHO_ENABLE = 2'd2
  } cfg_reg_e;

  localparam logic [4:0] INPUT_MODE_RST  = 5'd8;
  localparam logic [3:0] OUTPUT_MODE_RST = 4'd3;
  localparam logic       ECHO_ENABLE_RST = 1'b1;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       destination;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One pending result inside the block.
  typedef struct packed {
    logic       destination;
    logic [7:0] out_byte;
  } slot_t;

  // Everything one input item causes: the number of results and the results.
  typedef struct packed {
    logic [1:0]                 num;
    slot_t [MaxResults-1:0]     slot;
  } plan_t;

endpackage : ttybm_pkg

`default_nettype wire

[rtl/ttybm_front.sv]
// Front end: configuration registers and classification of each input byte
// into a plan of up to three results. Depends on ttybm_pkg.
`default_nettype none

module ttybm_front
  import ttybm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output plan_t                    plan_o
);

  typedef struct packed {
    logic [1:0]  num;
    slot_t [1:0] slot;
  } opath_t;

  logic [4:0] input_mode_q, input_mode_d;
  logic [3:0] output_mode_q, output_mode_d;
  logic       echo_enable_q, echo_enable_d;

  logic [7:0] c_strip, c_map, c_in, path_byte;
  logic       drop_cr;
  opath_t     op;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

  // Output post-processing of one byte: zero, one or two results.
  function automatic opath_t out_path(input logic [7:0] c, input logic [3:0] mode);
    opath_t r;
    r = '0;
    if (!mode[0]) begin
      r.num     = 2'd1;
      r.slot[0] = '{destination: DEST_OUTPUT, out_byte: c};
    end else if (c == CH_NL && mode[1]) begin
      r.num     = 2'd2;
      r.slot[0] = '{destination: DEST_OUTPUT, out_byte: CH_CR};
      r.slot[1] = '{destination: DEST_OUTPUT, out_byte: CH_NL};
    end else if (c == CH_CR && mode[2]) begin
      r.num = 2'd0;
    end else begin
      r.num     = 2'd1;
      r.slot[0] = '{destination: DEST_OUTPUT,
                    out_byte: (mode[3] && is_lower(c)) ? c - CASE_DELTA : c};
    end
    return r;
  endfunction

  always_comb begin
    input_mode_d  = input_mode_q;
    output_mode_d = output_mode_q;
    echo_enable_d = echo_enable_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INPUT_MODE:  input_mode_d  = cfg_wdata_i[4:0];
        REG_OUTPUT_MODE: output_mode_d = cfg_wdata_i[3:0];
        REG_ECHO_ENABLE: echo_enable_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_mode_q  <= INPUT_MODE_RST;
      output_mode_q <= OUTPUT_MODE_RST;
      echo_enable_q <= ECHO_ENABLE_RST;
    end else begin
      input_mode_q  <= input_mode_d;
      output_mode_q <= output_mode_d;
      echo_enable_q <= echo_enable_d;
    end
  end

  // Input mapping: strip, CR drop, NL/CR swap, then case folding.
  always_comb begin
    c_strip = input_mode_q[0] ? (in_item_i.data_byte & MASK_7BIT) : in_item_i.data_byte;
    drop_cr = input_mode_q[1] && (c_strip == CH_CR);
    if (input_mode_q[2] && c_strip == CH_NL) begin
      c_map = CH_CR;
    end else if (input_mode_q[3] && c_strip == CH_CR) begin
      c_map = CH_NL;
    end else begin
      c_map = c_strip;
    end
    c_in = (input_mode_q[4] && is_upper(c_map)) ? c_map + CASE_DELTA : c_map;
  end

  // The output path is shared by program bytes and echoed input bytes.
  assign path_byte = (in_item_i.action == ACT_TX) ? in_item_i.data_byte : c_in;
  assign op        = out_path(path_byte, output_mode_q);

  always_comb begin
    plan_o = '0;
    if (in_item_i.action == ACT_TX) begin
      plan_o.num     = op.num;
      plan_o.slot[0] = op.slot[0];
      plan_o.slot[1] = op.slot[1];
    end else if (!drop_cr) begin
      if (echo_enable_q) begin
        plan_o.slot[0]      = op.slot[0];
        plan_o.slot[1]      = op.slot[1];
        plan_o.slot[op.num] = '{destination: DEST_INPUT, out_byte: c_in};
        plan_o.num          = op.num + 2'd1;
      end else begin
        plan_o.slot[0] = '{destination: DEST_INPUT, out_byte: c_in};
        plan_o.num     = 2'd1;
      end
    end
  end

  // Items that give no result are accepted and simply not queued.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && (plan_o.num != 2'd0);

`ifndef SYNTH
  a_push_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (plan_o.num != 2'd0) && !q_full_i)
    else $error("plan queued while full or without results");
`endif

endmodule : ttybm_front

`default_nettype wire

[rtl/ttybm_queue.sv]
// Short plan queue between the front and back ends of the byte mapper.
// Depends on ttybm_pkg for the plan type.
`default_nettype none

module ttybm_queue
  import ttybm_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire plan_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output plan_t      data_o
);

  // Depth must be at least two.
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  plan_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("plan queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("plan queue count beyond depth");
`endif

endmodule : ttybm_queue

`default_nettype wire

[rtl/ttybm_back.sv]
// Back end: steps through the results of the head plan, one per cycle while the
// receiver takes them, into a registered output stage. Depends on ttybm_pkg.
`default_nettype none

module ttybm_back
  import ttybm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire plan_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       load, is_last;
  slot_t      cur;

  assign cur     = head_i.slot[idx_q];
  assign is_last = (idx_q == head_i.num - 2'd1);
  // The output register refills, while a plan is queued, whenever it is empty or being drained.
  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_d       = '{destination: cur.destination, out_byte: cur.out_byte, last: is_last};
      out_valid_d = 1'b1;
      idx_d       = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_idx_in_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> (idx_q < head_i.num))
    else $error("result index beyond the head plan");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && out_item_o.last && (idx_q == 2'd0))
    else $error("plan retired without a last result");
`endif

endmodule : ttybm_back

`default_nettype wire

[rtl/tty_line_discipline_byte_map_top.sv]
// Each accepted byte yields zero to three results, delivered one per clock cycle
// from a registered output stage while the receiver takes them, so the sustained
// rate is one result per cycle when the output is not stalled, and a byte gives
// three results in the worst case (NL expanded to CR NL and echoed). Bytes that
// give no result (a dropped CR) are accepted but not queued.
// The front end classifies a byte in its accept cycle and queues its results as
// one entry; the first result goes through the queue, then the output register.
// Input is refused only while the queue of QueueDepth entries (at least two) is
// full. Configuration writes take effect at the next clock edge.
// Top level of the byte mapper; depends on ttybm_pkg, ttybm_front,
// ttybm_queue and ttybm_back.
`default_nettype none

module tty_line_discipline_byte_map_top
  import ttybm_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_item_o
);

  logic  q_full, q_valid, push, pop;
  plan_t push_plan, head_plan;

  ttybm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .plan_o      (push_plan)
  );

  ttybm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_plan),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_plan)
  );

  ttybm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_plan),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule : tty_line_discipline_byte_map_top

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the terminal line-discipline byte mapper.
// Depends on ttybm_pkg and tty_line_discipline_byte_map_top; predicts every result
// from a shadow copy of the mode registers and checks the results in order.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ttybm_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 45;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] REG_SPARE_INDEX = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;

  // Shadow copy of the mode registers.
  logic [4:0] rx_flags;
  logic [3:0] tx_flags;
  logic       echo_on;

  out_item_t   mapped_bytes[$];
  out_item_t   staged_bytes[$];
  out_item_t   oldest;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_request = 1'b0;
  logic        hold_active  = 1'b0;

  tty_line_discipline_byte_map_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic void stage_byte(input logic dest, input logic [7:0] b);
    staged_bytes.push_back('{destination: dest, out_byte: b, last: 1'b0});
  endfunction

  function automatic void map_tx_byte(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (!tx_flags[0]) begin
      stage_byte(DEST_OUTPUT, c);
    end else if (c == CH_NL && tx_flags[1]) begin
      stage_byte(DEST_OUTPUT, CH_CR);
      stage_byte(DEST_OUTPUT, CH_NL);
    end else if (!(c == CH_CR && tx_flags[2])) begin
      if (tx_flags[3] && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        c = c - CASE_DELTA;
      end
      stage_byte(DEST_OUTPUT, c);
    end
  endfunction

  // Works out every result of one accepted request and queues them in order.
  function automatic void map_request(input in_item_t req);
    logic [7:0] c;
    c = req.data_byte;
    staged_bytes.delete();
    if (req.action == ACT_TX) begin
      map_tx_byte(c);
    end else begin
      if (rx_flags[0]) begin
        c = c & MASK_7BIT;
      end
      // A CR dropped on input yields nothing at all, not even an echo.
      if (!(rx_flags[1] && c == CH_CR)) begin
        if (rx_flags[2] && c == CH_NL) begin
          c = CH_CR;
        end else if (rx_flags[3] && c == CH_CR) begin
          c = CH_NL;
        end
        if (rx_flags[4] && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
          c = c + CASE_DELTA;
        end
        if (echo_on) begin
          map_tx_byte(c);
        end
        stage_byte(DEST_INPUT, c);
      end
    end
    if (staged_bytes.size() > 0) begin
      staged_bytes[staged_bytes.size() - 1].last = 1'b1;
    end
    foreach (staged_bytes[k]) begin
      mapped_bytes.push_back(staged_bytes[k]);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return CH_NL;
      1: return CH_CR;
      2: return ($urandom_range(0, 1) != 0) ? (CH_NL | 8'h80) : (CH_CR | 8'h80);
      3: return 8'($urandom_range(8'h40, 8'h5B));
      4: return 8'($urandom_range(8'h60, 8'h7B));
      5: return 8'($urandom_range(8'h40, 8'h7B)) | 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_byte(input logic act, input logic [7:0] b);
    in_item_t req;
    req = '{action: act, data_byte: b};
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat (gap_length()) @(posedge clk_i);
    end
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    map_request(req);
  endtask

  // Waits until every result has arrived and a dropped byte has had time to pass.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (mapped_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_INPUT_MODE) begin
      rx_flags = val[4:0];
    end else if (idx == REG_OUTPUT_MODE) begin
      tx_flags = val[3:0];
    end else if (idx == REG_ECHO_ENABLE) begin
      echo_on = val[0];
    end
  endtask

  task automatic configure(input logic [4:0] rx, input logic [4:0] tx, input logic [4:0] echo);
    wait_idle();
    write_reg(REG_INPUT_MODE, rx);
    write_reg(REG_OUTPUT_MODE, tx);
    write_reg(REG_ECHO_ENABLE, echo);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_byte(ACT_RX, CH_CR);
    send_byte(ACT_TX, CH_LOWER_A);
    send_byte(ACT_TX, CH_NL);
    send_byte(ACT_TX, 8'hFF);
  endtask

  task automatic test_register_writes();
    wait_idle();
    // Upper bits beyond each register's width are discarded.
    write_reg(REG_OUTPUT_MODE, 5'h1F);
    write_reg(REG_ECHO_ENABLE, 5'h1E);
    write_reg(REG_INPUT_MODE, 5'h00);
    write_reg(REG_SPARE_INDEX, 5'h1F);
    cfg_we_i <= 1'b0;
    send_byte(ACT_TX, CH_CR);
    send_byte(ACT_TX, CH_LOWER_Z);
    send_byte(ACT_RX, 8'h51);
  endtask

  task automatic test_input_mapping();
    configure(5'h1F, 5'h00, 5'h01);
    send_byte(ACT_RX, CH_CR | 8'h80);
    send_byte(ACT_RX, CH_NL | 8'h80);
    send_byte(ACT_RX, CH_UPPER_A);
    send_byte(ACT_RX, CH_UPPER_Z);
    send_byte(ACT_RX, 8'h40);
    send_byte(ACT_RX, 8'h5B);
    send_byte(ACT_RX, 8'hC1);
    // Both newline swaps on together: each byte takes only one of them.
    configure(5'h0C, 5'h00, 5'h01);
    send_byte(ACT_RX, CH_CR);
    send_byte(ACT_RX, CH_NL);
    configure(5'h00, 5'h00, 5'h01);
    send_byte(ACT_RX, 8'hFF);
    send_byte(ACT_RX, 8'h00);
  endtask

  task automatic test_output_mapping();
    configure(5'h00, 5'h0F, 5'h01);
    send_byte(ACT_TX, CH_LOWER_A);
    send_byte(ACT_TX, 8'h60);
    send_byte(ACT_TX, 8'h7B);
    send_byte(ACT_TX, CH_NL);
    send_byte(ACT_RX, CH_CR);
    configure(5'h00, 5'h09, 5'h01);
    send_byte(ACT_TX, CH_NL);
  endtask

  // The receiver stops for a long stretch while requests keep coming,
  // so the internal queue fills and the input side is refused.
  task automatic test_backpressure();
    configure(5'h08, 5'h03, 5'h01);
    tx_gap_pct   = 0;
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk_i);
    repeat (12) send_byte(ACT_RX, CH_CR);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          configure(5'h1F, 5'h0F, 5'h01);
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        1: begin
          configure(5'h00, 5'h00, 5'h00);
          tx_gap_pct   = 50;
          rx_stall_pct = 50;
        end
        default: begin
          configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 15)),
                    5'($urandom_range(0, 1)));
          tx_gap_pct   = $urandom_range(10, 60);
          rx_stall_pct = $urandom_range(10, 60);
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_byte(1'($urandom_range(0, 1)), pick_byte());
      end
    end
  endtask

  initial begin : result_receiver
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        hold_active  = 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat (gap_length()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mapped_bytes.size() == 0) begin
        $error("unexpected result: destination %0d, out_byte %02h, last %0d",
               out_item_o.destination, out_item_o.out_byte, out_item_o.last);
        fail_count++;
      end else begin
        oldest = mapped_bytes.pop_front();
        if (out_item_o.destination !== oldest.destination) begin
          $error("destination: expected %0d, actual %0d",
                 oldest.destination, out_item_o.destination);
          fail_count++;
        end
        if (out_item_o.out_byte !== oldest.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", oldest.out_byte, out_item_o.out_byte);
          fail_count++;
        end
        if (out_item_o.last !== oldest.last) begin
          $error("last: expected %0d, actual %0d", oldest.last, out_item_o.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sequencer
    repeat (5) @(posedge clk_i);
    rst_ni   <= 1'b1;
    rx_flags = INPUT_MODE_RST;
    tx_flags = OUTPUT_MODE_RST;
    echo_on  = ECHO_ENABLE_RST;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_writes();
    test_input_mapping();
    test_output_mapping();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
